>>> rtl/core/b2d_pkg.sv
// Shared types and constants for the binary to decimal digit converter.
`default_nettype none

package b2d_pkg;

  // Default width of the converted value.
  localparam int VALUE_WIDTH_DEFAULT = 64;

  // Width of one packed decimal digit.
  localparam int DIGIT_W = 4;

  // Width of one output character and the code of the character zero.
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // States of the conversion front end.
  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_PUSH
  } front_state_t;

endpackage

`default_nettype wire

>>> rtl/core/b2d_front.sv
// Front end: accepts a binary value and converts it bit by bit to packed decimal.
`default_nettype none

module b2d_front #(
  parameter int VALUE_WIDTH = 64,
  parameter int DIGITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [63:0]            value,
  output logic                        q_valid,
  input  wire logic                   q_ready,
  output logic [4*DIGITS-1:0]         q_data
);
  import b2d_pkg::*;

  localparam int BCD_W = DIGIT_W * DIGITS;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  front_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] sh, sh_next;
  logic [BCD_W-1:0]       bcd, bcd_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [BCD_W-1:0]       bcd_adj;

  // Add three to every digit that is five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Next state, datapath updates and handshake outputs.
  always_comb begin
    state_next = state;
    sh_next    = sh;
    bcd_next   = bcd;
    count_next = count;
    in_ready   = 1'b0;
    q_valid    = 1'b0;
    unique case (state)
      FRONT_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sh_next    = value[VALUE_WIDTH-1:0];
          bcd_next   = '0;
          count_next = CNT_W'(VALUE_WIDTH - 1);
          state_next = FRONT_CONV;
        end
      end
      FRONT_CONV: begin
        bcd_next = {bcd_adj[BCD_W-2:0], sh[VALUE_WIDTH-1]};
        sh_next  = {sh[VALUE_WIDTH-2:0], 1'b0};
        if (count == '0) begin
          state_next = FRONT_PUSH;
        end else begin
          count_next = count - 1'b1;
        end
      end
      FRONT_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_next = FRONT_IDLE;
        end
      end
      default: begin
        state_next = FRONT_IDLE;
      end
    endcase
  end

  assign q_data = bcd;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    sh    <= sh_next;
    bcd   <= bcd_next;
    count <= count_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/b2d_queue.sv
// Two-entry queue that carries packed decimal words from front end to back end.
`default_nettype none

module b2d_queue #(
  parameter int WIDTH = 80
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/b2d_back.sv
// Back end: drops leading zeros and sends one ASCII digit per transfer.
`default_nettype none

module b2d_back #(
  parameter int DIGITS = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_ready,
  input  wire logic [4*DIGITS-1:0]          q_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [b2d_pkg::CHAR_W-1:0]        digit_char,
  output logic                              last
);
  import b2d_pkg::*;

  localparam int BCD_W  = DIGIT_W * DIGITS;
  localparam int LEFT_W = $clog2(DIGITS + 1);

  logic                busy, busy_next;
  logic                started, started_next;
  logic [BCD_W-1:0]    dig, dig_next;
  logic [LEFT_W-1:0]   left, left_next;
  logic                out_valid_next;
  logic [CHAR_W-1:0]   digit_char_next;
  logic                last_next;
  logic [DIGIT_W-1:0]  top;
  logic                out_free;

  assign top      = dig[BCD_W-1 -: DIGIT_W];
  assign out_free = !out_valid || out_ready;
  assign q_ready  = !busy;

  // Load a word, skip leading zeros, then emit digits into the output register.
  always_comb begin
    busy_next       = busy;
    started_next    = started;
    dig_next        = dig;
    left_next       = left;
    digit_char_next = digit_char;
    last_next       = last;
    out_valid_next  = out_valid && !out_ready;
    if (!busy) begin
      if (q_valid) begin
        dig_next     = q_data;
        left_next    = LEFT_W'(DIGITS);
        started_next = 1'b0;
        busy_next    = 1'b1;
      end
    end else if (!started && top == '0 && left != LEFT_W'(1)) begin
      dig_next  = {dig[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      left_next = left - 1'b1;
    end else if (out_free) begin
      out_valid_next  = 1'b1;
      digit_char_next = ASCII_ZERO + CHAR_W'(top);
      last_next       = (left == LEFT_W'(1));
      dig_next        = {dig[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      left_next       = left - 1'b1;
      started_next    = 1'b1;
      if (left == LEFT_W'(1)) begin
        busy_next = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      started   <= started_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dig        <= dig_next;
    left       <= left_next;
    digit_char <= digit_char_next;
    last       <= last_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/binary_to_decimal_digits_top.sv
// Top level of the binary to decimal digit converter.
//
// Each accepted value (its low VALUE_WIDTH bits) is sent out as ASCII decimal
// digits, most significant first, with no leading zeros; the final digit has
// last set and zero gives a single '0'. The front end converts with a
// shift-add-3 loop, one input bit per step, and takes no new value until
// its result has been handed to the queue. A two-entry queue lets the front
// end convert the next value while the back end, which loads a word, skips
// its leading zeros and then sends its digits, drains the previous one. The
// output is registered; an item is accepted whenever in_valid and in_ready
// are both high.
`default_nettype none

module binary_to_decimal_digits_top #(
  parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [63:0]               value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [b2d_pkg::CHAR_W-1:0]     digit_char,
  output logic                           last
);
  import b2d_pkg::*;

  // Decimal digits needed for the largest value: ceil(VALUE_WIDTH * log10(2)).
  localparam int DIGITS = (VALUE_WIDTH * 30103 + 99999) / 100000;
  localparam int BCD_W  = DIGIT_W * DIGITS;

  logic             fq_valid;
  logic             fq_ready;
  logic [BCD_W-1:0] fq_data;
  logic             qb_valid;
  logic             qb_ready;
  logic [BCD_W-1:0] qb_data;

  b2d_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  b2d_queue #(
    .WIDTH (BCD_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  b2d_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule

`default_nettype wire

>>> dv/binary_to_decimal_digits_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the decimal digit stream of the converter.
module binary_to_decimal_digits_checker #(
  parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [63:0]                value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [b2d_pkg::CHAR_W-1:0] digit_char,
  input  logic                       last,
  output int                         fail_count,
  output int                         digits_pending
);
  import b2d_pkg::*;

  // A 64-bit value never needs more than twenty decimal digits.
  localparam int MAX_DIGITS = 20;

  // Only the low VALUE_WIDTH bits of a value take part; widths below one act as one.
  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? {64{1'b1}} :
    (VALUE_WIDTH < 1)   ? 64'd1 :
                          ((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } digit_t;

  // Digits still owed by the block, oldest first.
  digit_t expected_digits[$];
  int     failures = 0;
  int     pending_count = 0;

  assign fail_count     = failures;
  assign digits_pending = pending_count;

  // Split one value into decimal digits and queue them most significant first.
  task automatic queue_decimal_digits(input logic [63:0] raw);
    logic [63:0] rest;
    logic [3:0]  rev [MAX_DIGITS];
    int          count;
    digit_t      d;
    rest  = raw & VALUE_MASK;
    count = 0;
    do begin
      rev[count] = 4'(rest % 64'd10);
      rest       = rest / 64'd10;
      count++;
    end while (rest != 64'd0 && count < MAX_DIGITS);
    for (int k = count - 1; k >= 0; k--) begin
      d.char_code = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, rev[k]};
      d.last      = (k == 0);
      expected_digits.push_back(d);
    end
  endtask

  // Compare each output transfer with the oldest owed digit, then record new input.
  always @(posedge clk) begin
    digit_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          failures++;
          $display("%0t: unexpected digit: expected none, got char %0d last %0b",
                   $time, digit_char, last);
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.char_code) begin
            failures++;
            $display("%0t: digit_char wrong: expected %0d, got %0d",
                     $time, want.char_code, digit_char);
          end
          if (last !== want.last) begin
            failures++;
            $display("%0t: last wrong: expected %0b, got %0b", $time, want.last, last);
          end
        end
      end
      if (in_valid && in_ready) begin
        queue_decimal_digits(value);
      end
      pending_count = expected_digits.size();
    end
  end

endmodule

>>> dv/binary_to_decimal_digits_top_tb.sv
`timescale 1ns / 100ps
// Testbench top that drives values into the converter and gives the verdict.
module binary_to_decimal_digits_top_tb;
  import b2d_pkg::*;

  // Which side idles, and how often, in each part of the run.
  typedef enum int {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_NO_IDLE
  } idle_phase_t;

  localparam int RESET_CYCLES    = 7;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 33;
  localparam int SETTLE_CYCLES   = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [63:0]       value = 64'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] digit_char;
  logic              last;
  int                fail_count;
  int                digits_pending;
  idle_phase_t       phase = PH_SLOW_SINK;

  binary_to_decimal_digits_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

  binary_to_decimal_digits_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digit_char     (digit_char),
    .last           (last),
    .fail_count     (fail_count),
    .digits_pending (digits_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Percent of cycles in which the sender holds back.
  function automatic int source_idle_pct(input idle_phase_t p);
    case (p)
      PH_SLOW_SINK:   return 29;
      PH_SLOW_SOURCE: return 75;
      default:        return 0;
    endcase
  endfunction

  // Percent of cycles in which the receiver refuses a digit.
  function automatic int sink_idle_pct(input idle_phase_t p);
    case (p)
      PH_SLOW_SINK:   return 75;
      PH_SLOW_SOURCE: return 29;
      default:        return 0;
    endcase
  endfunction

  // Mostly values of random magnitude, with some near a power of ten.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int unsigned span;
    if ($urandom_range(4) == 0) begin
      v = 64'd1;
      repeat ($urandom_range(19)) v = v * 64'd10;
      v = v + 64'($urandom_range(2)) - 64'd1;
    end else begin
      v    = {$urandom, $urandom};
      span = $urandom_range(64, 1);
      if (span < 64) begin
        v = v & ((64'd1 << span) - 64'd1);
      end
    end
    return v;
  endfunction

  // Offer one value after a random gap and hold it until the transfer.
  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(99) < source_idle_pct(phase)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls per phase, and one long hold-off once idling stops.
  initial begin : sink
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (phase == PH_NO_IDLE && held < HOLD_OFF_CYCLES) begin
        out_ready <= 1'b0;
        held++;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct(phase));
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero, digit-count boundaries, the largest value and alternating bit patterns.
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd11);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd999);
    send_value(64'd1000);
    send_value(64'd4294967295);
    send_value(64'd4294967296);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd9999999999999999999);
    send_value(64'd10000000000000000000);
    send_value(64'd18446744073709551614);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'd1234567890123456789);
    send_value(64'd9876543210);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);

    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(random_value());
    phase = PH_SLOW_SOURCE;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(random_value());
    phase = PH_NO_IDLE;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(random_value());
    in_valid <= 1'b0;

    // Let the checker see the final transfer, drain, then watch for stray digits.
    @(posedge clk);
    wait (digits_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("binary_to_decimal_digits_top: match");
    end else begin
      $display("binary_to_decimal_digits_top: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(2_000_000);
    $display("binary_to_decimal_digits_top: mismatch");
    $finish;
  end

endmodule

>>> binary_to_decimal_digits_top.f
rtl/core/b2d_pkg.sv
rtl/core/b2d_front.sv
rtl/core/b2d_queue.sv
rtl/core/b2d_back.sv
rtl/core/binary_to_decimal_digits_top.sv
dv/binary_to_decimal_digits_checker.sv
dv/binary_to_decimal_digits_top_tb.sv
